### sv/fuzzy_pd_gain_lookup_macros.svh
// Assertion macros for the fuzzy gain lookup block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef FUZZY_PD_GAIN_LOOKUP_MACROS_SVH
`define FUZZY_PD_GAIN_LOOKUP_MACROS_SVH

// same-cycle implication, masked during reset
`define FPGL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define FPGL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fpgl_pkg.sv
// Shared types, constants and tables of the fuzzy gain lookup block.
// No dependencies; imported by every module of the block.
package fpgl_pkg;

    localparam int NUM_LEVELS  = 7;
    localparam int NUM_EBP     = 7;
    localparam int NUM_RBP     = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam int IN_W    = 16;
    localparam int LEVEL_W = 16;
    localparam int IDX_W   = 3;
    localparam int RULE_W  = 3;
    localparam int SEG_W   = 3;
    localparam int WE_W    = 12;
    localparam int WR_W    = 10;
    localparam int PROD_W  = 26;
    localparam int NUM_W   = 38;
    localparam int SH_W    = 5;
    localparam int DIV_W   = 5;
    localparam int REM_W   = 6;
    localparam int Q_W     = 21;
    localparam int RECIP_W = 21;
    localparam int QM_W    = Q_W + RECIP_W;
    localparam int RECIP_SHIFT = 24;
    localparam int SHIFT_BASE  = 16;

    typedef logic [LEVEL_W-1:0]          t_level;
    typedef t_level [NUM_LEVELS-1:0]     t_levels;
    typedef logic [RULE_W-1:0]           t_rule;
    typedef logic signed [IN_W-1:0]      t_sample;

    typedef struct packed {
        t_rule [3:0]     rule;
        logic            e_wide;
        logic            r_wide;
        logic [WE_W-1:0] w_err;
        logic [WR_W-1:0] w_rate;
    } t_cls;

    localparam t_sample ERR_BP [NUM_EBP] = '{
        -16'sd6144, -16'sd3072, -16'sd1536, 16'sd0, 16'sd1536, 16'sd3072, 16'sd6144
    };
    localparam t_sample RATE_BP [NUM_RBP] = '{
        -16'sd1664, -16'sd768, 16'sd0, 16'sd768, 16'sd1664
    };

    localparam logic [WE_W-1:0] ERR_WIDE_SPAN    = 12'd3072;
    localparam logic [WE_W-1:0] ERR_NARROW_SPAN  = 12'd1536;
    localparam logic [WR_W-1:0] RATE_WIDE_SPAN   = 10'd896;
    localparam logic [WR_W-1:0] RATE_NARROW_SPAN = 10'd768;

    localparam logic [DIV_W-1:0]   DIV_WIDE     = 5'd21;
    localparam logic [DIV_W-1:0]   DIV_NARROW   = 5'd9;
    localparam logic [RECIP_W-1:0] RECIP_WIDE   = 21'd798915;
    localparam logic [RECIP_W-1:0] RECIP_NARROW = 21'd1864135;

    localparam t_rule RULE_TAB [NUM_EBP][NUM_RBP] = '{
        '{3'd1, 3'd1, 3'd1, 3'd0, 3'd0},
        '{3'd4, 3'd2, 3'd1, 3'd0, 3'd0},
        '{3'd6, 3'd4, 3'd1, 3'd1, 3'd0},
        '{3'd3, 3'd3, 3'd0, 3'd3, 3'd3},
        '{3'd0, 3'd1, 3'd1, 3'd4, 3'd6},
        '{3'd0, 3'd0, 3'd1, 3'd2, 3'd4},
        '{3'd0, 3'd0, 3'd1, 3'd1, 3'd1}
    };

    localparam t_level LEVEL_RESET [NUM_LEVELS] = '{
        16'd0, 16'd3840, 16'd5120, 16'd8960, 16'd12800, 16'd20480, 16'd30720
    };

    function automatic t_rule fpgl_rule(input logic [SEG_W-1:0] ke, input logic [SEG_W-1:0] kr);
        return RULE_TAB[ke][kr];
    endfunction

endpackage

### sv/fpgl_front.sv
// Front end: accepts items, clamps and locates both inputs among the breakpoints.
// Produces segment weights and corner rule codes. Depends on fpgl_pkg.
module fpgl_front import fpgl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_sample i_error_value,
    input  t_sample i_error_rate,
    output logic    o_cls_valid,
    input  logic    i_cls_ready,
    output t_cls    o_cls
);

    t_sample          w_ec;
    t_sample          w_rc;
    t_sample          w_ehi;
    t_sample          w_rhi;
    t_sample          w_ediff;
    t_sample          w_rdiff;
    logic [SEG_W-1:0] w_ke;
    logic [SEG_W-1:0] w_kr;
    t_cls             n_cls;
    logic             r_valid;
    t_cls             r_cls;

    always_comb begin
        if (i_error_value < ERR_BP[0]) begin
            w_ec = ERR_BP[0];
        end else if (i_error_value > ERR_BP[NUM_EBP-1]) begin
            w_ec = ERR_BP[NUM_EBP-1];
        end else begin
            w_ec = i_error_value;
        end
        if (i_error_rate < RATE_BP[0]) begin
            w_rc = RATE_BP[0];
        end else if (i_error_rate > RATE_BP[NUM_RBP-1]) begin
            w_rc = RATE_BP[NUM_RBP-1];
        end else begin
            w_rc = i_error_rate;
        end
        w_ke = '0;
        for (int i = 1; i < NUM_EBP - 1; i++) begin
            if (ERR_BP[i] < w_ec) w_ke = w_ke + SEG_W'(1);
        end
        w_kr = '0;
        for (int i = 1; i < NUM_RBP - 1; i++) begin
            if (RATE_BP[i] < w_rc) w_kr = w_kr + SEG_W'(1);
        end
        w_ehi   = ERR_BP[w_ke + SEG_W'(1)];
        w_rhi   = RATE_BP[w_kr + SEG_W'(1)];
        w_ediff = w_ehi - w_ec;
        w_rdiff = w_rhi - w_rc;

        n_cls.w_err   = w_ediff[WE_W-1:0];
        n_cls.w_rate  = w_rdiff[WR_W-1:0];
        n_cls.e_wide  = (w_ke == SEG_W'(0)) || (w_ke == SEG_W'(NUM_EBP - 2));
        n_cls.r_wide  = (w_kr == SEG_W'(0)) || (w_kr == SEG_W'(NUM_RBP - 2));
        n_cls.rule[0] = fpgl_rule(w_ke, w_kr);
        n_cls.rule[1] = fpgl_rule(w_ke, w_kr + SEG_W'(1));
        n_cls.rule[2] = fpgl_rule(w_ke + SEG_W'(1), w_kr);
        n_cls.rule[3] = fpgl_rule(w_ke + SEG_W'(1), w_kr + SEG_W'(1));
    end

    assign o_in_ready  = !r_valid || i_cls_ready;
    assign o_cls_valid = r_valid;
    assign o_cls       = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cls <= n_cls;
        end
    end

endmodule

### sv/fpgl_queue.sv
// Short queue of classified items between the front and back ends.
// Depth set by parameter DEPTH (2 or more). Depends on fpgl_pkg.
module fpgl_queue import fpgl_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cls i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_cls o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### sv/fpgl_back.sv
// Back end: six-stage pipeline forming the bilinear sum and the rounded quotient.
// Division by the span product uses a shift and a reciprocal multiply. Depends on fpgl_pkg.
module fpgl_back import fpgl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  t_cls               i_q,
    input  t_levels            i_levels,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [LEVEL_W-1:0] o_drive_value
);

    logic [5:0]          r_vld;
    logic                w_adv;

    logic [WR_W-1:0]     w_cb;
    logic [PROD_W-1:0]   r1_p [4];
    logic [WE_W-1:0]     r1_a;
    logic [WE_W-1:0]     r1_ca;
    logic                r1_ew;
    logic                r1_rw;

    logic [PROD_W-1:0]   r2_row0;
    logic [PROD_W-1:0]   r2_row1;
    logic [WE_W-1:0]     r2_a;
    logic [WE_W-1:0]     r2_ca;
    logic                r2_ew;
    logic                r2_rw;

    logic [NUM_W-1:0]    r3_m0;
    logic [NUM_W-1:0]    r3_m1;
    logic                r3_ew;
    logic                r3_rw;

    logic [SH_W-1:0]     w_shift;
    logic [NUM_W-1:0]    w_half;
    logic [NUM_W-1:0]    n_t;
    logic [Q_W-1:0]      r4_q;
    logic                r4_rw;

    logic [QM_W-1:0]     w_qm;
    logic [Q_W-1:0]      r5_q;
    logic [LEVEL_W-1:0]  r5_qh;
    logic                r5_rw;

    logic [DIV_W-1:0]    w_div;
    logic [Q_W-1:0]      w_back;
    logic [Q_W-1:0]      w_diff;
    logic [REM_W-1:0]    w_rem;
    logic [LEVEL_W-1:0]  n_res;
    logic [LEVEL_W-1:0]  r6_res;

    assign w_adv       = !r_vld[5] || i_out_ready;
    assign o_q_ready   = w_adv;
    assign o_out_valid = r_vld[5];
    assign o_drive_value = r6_res;

    assign w_cb    = (i_q.r_wide ? RATE_WIDE_SPAN : RATE_NARROW_SPAN) - i_q.w_rate;
    assign w_shift = SH_W'(SHIFT_BASE) + SH_W'(r3_ew) + SH_W'(!r3_rw);
    assign w_half  = NUM_W'(r3_rw ? DIV_WIDE : DIV_NARROW) << (w_shift - SH_W'(1));
    assign n_t     = r3_m0 + r3_m1 + w_half;
    assign w_qm    = QM_W'(r4_q) * QM_W'(r4_rw ? RECIP_WIDE : RECIP_NARROW);
    assign w_div   = r5_rw ? DIV_WIDE : DIV_NARROW;
    assign w_back  = Q_W'(r5_qh) * Q_W'(w_div);
    assign w_diff  = r5_q - w_back;
    assign w_rem   = w_diff[REM_W-1:0];
    assign n_res   = (w_rem >= REM_W'(w_div)) ? r5_qh + LEVEL_W'(1) : r5_qh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[4:0], i_q_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_p[0] <= PROD_W'(i_levels[i_q.rule[0]]) * PROD_W'(i_q.w_rate);
            r1_p[1] <= PROD_W'(i_levels[i_q.rule[1]]) * PROD_W'(w_cb);
            r1_p[2] <= PROD_W'(i_levels[i_q.rule[2]]) * PROD_W'(i_q.w_rate);
            r1_p[3] <= PROD_W'(i_levels[i_q.rule[3]]) * PROD_W'(w_cb);
            r1_a    <= i_q.w_err;
            r1_ca   <= (i_q.e_wide ? ERR_WIDE_SPAN : ERR_NARROW_SPAN) - i_q.w_err;
            r1_ew   <= i_q.e_wide;
            r1_rw   <= i_q.r_wide;

            r2_row0 <= r1_p[0] + r1_p[1];
            r2_row1 <= r1_p[2] + r1_p[3];
            r2_a    <= r1_a;
            r2_ca   <= r1_ca;
            r2_ew   <= r1_ew;
            r2_rw   <= r1_rw;

            r3_m0   <= NUM_W'(r2_row0) * NUM_W'(r2_a);
            r3_m1   <= NUM_W'(r2_row1) * NUM_W'(r2_ca);
            r3_ew   <= r2_ew;
            r3_rw   <= r2_rw;

            r4_q    <= Q_W'(n_t >> w_shift);
            r4_rw   <= r3_rw;

            r5_q    <= r4_q;
            r5_qh   <= w_qm[RECIP_SHIFT +: LEVEL_W];
            r5_rw   <= r4_rw;

            r6_res  <= n_res;
        end
    end

endmodule

### sv/fuzzy_pd_gain_lookup.sv
// Fuzzy PD gain lookup: 7x5 rule table, bilinear defuzzification, Q8.8 in and out.
// Top level; holds the level registers. Depends on fpgl_pkg, fpgl_front, fpgl_queue,
// fpgl_back and fuzzy_pd_gain_lookup_macros.svh.
//
// Input channel: i_in_valid / o_in_ready with i_error_value and i_error_rate (signed Q8.8).
// Output channel: o_out_valid / i_out_ready with o_drive_value (unsigned Q8.8).
// Config channel: i_cfg_valid / o_cfg_ready, i_cfg_index 0..6 selects level_0..level_6,
// i_cfg_data is the new level; index 7 is ignored. o_cfg_ready is always high.
// Write the levels only while no item is in flight.
// Path from the accepting edge to o_out_valid when the queue is empty:
// one front register, one queue slot, six back stages (multiplies, shift, reciprocal
// multiply, correction). Throughput: one item per cycle while no result waits on a low
// i_out_ready; the back pipeline advances whenever its last stage is empty or taken.
// Stall: when i_out_ready is low with a result waiting, the back pipeline holds and the
// queue (QUEUE_DEPTH_P items) and front register keep accepting until full; then
// o_in_ready drops. Nothing is lost or repeated.
// Reset (synchronous, active low): pipeline and queue empty, levels back to defaults.
`include "fuzzy_pd_gain_lookup_macros.svh"

module fuzzy_pd_gain_lookup import fpgl_pkg::*; #(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_sample            i_error_value,
    input  t_sample            i_error_rate,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [LEVEL_W-1:0] o_drive_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [LEVEL_W-1:0] i_cfg_data
);

    t_levels r_levels;
    logic    w_front_valid;
    logic    w_q_in_ready;
    t_cls    w_front_cls;
    logic    w_q_valid;
    logic    w_q_ready;
    t_cls    w_q_cls;
    logic    w_q_pop;

    assign o_cfg_ready = 1'b1;
    assign w_q_pop     = w_q_valid && w_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_levels[i] <= LEVEL_RESET[i];
            end
        end else if (i_cfg_valid && (i_cfg_index < IDX_W'(NUM_LEVELS))) begin
            r_levels[i_cfg_index] <= i_cfg_data;
        end
    end

    fpgl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_error_value (i_error_value),
        .i_error_rate  (i_error_rate),
        .o_cls_valid   (w_front_valid),
        .i_cls_ready   (w_q_in_ready),
        .o_cls         (w_front_cls)
    );

    fpgl_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .o_ready (w_q_in_ready),
        .i_data  (w_front_cls),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_cls)
    );

    fpgl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .o_q_ready     (w_q_ready),
        .i_q           (w_q_cls),
        .i_levels      (r_levels),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_drive_value (o_drive_value)
    );

    `FPGL_ASSERT_NXT(a_front_load, i_in_valid && o_in_ready, w_front_valid, "item lost at front")
    `FPGL_ASSERT_NXT(a_front_hold, w_front_valid && !w_q_in_ready, w_front_valid, "front dropped item")
    `FPGL_ASSERT_IMP(a_back_stall, o_out_valid && !i_out_ready, !w_q_pop, "queue popped in stall")

endmodule
